// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising edge, masked while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Condition that must never be seen at a rising edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_PROP(lbl, clk, rst_n, !(cond))

`endif

// File: sv/rc4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int TABLE_SIZE        = 256;
    localparam int BYTE_W            = 8;
    localparam int DEFAULT_KEY_DEPTH = 256;
    localparam int KEY_LEN_W         = 9;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    typedef enum logic [1:0] {
        OP_KEY     = 2'd0,
        OP_RESTART = 2'd1,
        OP_CRYPT   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_CR_RD_X,
        ST_CR_RD_Y,
        ST_CR_WR_X,
        ST_CR_WR_Y,
        ST_CR_DONE
    } state_t;

    // permutation memory access
    typedef struct packed {
        logic              rd_en;
        logic [BYTE_W-1:0] rd_addr;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              clear;
    } sbox_req_t;

    // key store access
    typedef struct packed {
        logic              rd_en;
        logic [BYTE_W-1:0] rd_addr;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } key_req_t;

endpackage

// File: sv/rc4_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_key_ram
// Key byte store, one write and one registered read per cycle.
// Entries never written read as zero (per-entry valid bits).
// ----------------------------------------------------------------------------
module rc4_key_ram
    import rc4_pkg::*;
#(
    parameter int KEY_DEPTH = DEFAULT_KEY_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_req_t          req,
    output logic [BYTE_W-1:0] rdata
);

    localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    logic [BYTE_W-1:0]    key_mem [KEY_DEPTH];
    logic [KEY_DEPTH-1:0] valid_reg;
    logic [BYTE_W-1:0]    data_reg;
    logic                 rd_valid_reg;
    logic                 wr_ok;

    // writes beyond the store depth are dropped
    assign wr_ok = req.wr_en && ({1'b0, req.wr_addr} < 9'(KEY_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            key_mem[req.wr_addr[KIDX_W-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= key_mem[req.rd_addr[KIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[req.wr_addr[KIDX_W-1:0]] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr[KIDX_W-1:0]];
            end
        end
    end

    assign rdata = rd_valid_reg ? data_reg : '0;

endmodule

// File: sv/rc4_sbox_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_sbox_ram
// 256-entry permutation memory, one write and one registered read per cycle.
// An entry whose valid bit is clear reads as its own address, so a single
// clear pulse restores the identity permutation.
// ----------------------------------------------------------------------------
module rc4_sbox_ram
    import rc4_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sbox_req_t         req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0]     sbox_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [BYTE_W-1:0]     data_reg;
    logic [BYTE_W-1:0]     rd_addr_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            sbox_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg    <= sbox_mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? data_reg : rd_addr_reg;

endmodule

// File: sv/rc4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key writes, key schedule and keystream generation, built
// around one shared 8-bit three-operand adder.
// ----------------------------------------------------------------------------
module rc4_ctrl
    import rc4_pkg::*;
#(
    parameter int KEY_DEPTH = DEFAULT_KEY_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [BYTE_W-1:0]    key_index,
    input  logic [BYTE_W-1:0]    value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    input  logic [KEY_LEN_W-1:0] key_len,
    output sbox_req_t            sbox_req,
    input  logic [BYTE_W-1:0]    sbox_rdata,
    output key_req_t             key_req,
    input  logic [BYTE_W-1:0]    key_rdata
);

    localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    state_t              state_reg, state_next;
    logic [BYTE_W-1:0]   i_reg, i_next;
    logic [BYTE_W-1:0]   j_reg, j_next;
    logic [KIDX_W-1:0]   k_reg, k_next;
    logic [BYTE_W-1:0]   ix_reg, ix_next;
    logic [BYTE_W-1:0]   iy_reg, iy_next;
    logic [BYTE_W-1:0]   x_reg, x_next;
    logic [BYTE_W-1:0]   y_reg, y_next;
    logic [BYTE_W-1:0]   t_reg, t_next;
    logic [BYTE_W-1:0]   sx_reg, sx_next;
    logic [BYTE_W-1:0]   sy_reg, sy_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0]   add_a, add_b, add_c, add_sum;
    logic [KIDX_W:0]     k_inc;
    logic                k_wrap;
    logic [BYTE_W-1:0]   ks_byte;
    logic                accept;

    // shared adder
    assign add_sum = add_a + add_b + add_c;

    assign k_inc  = {1'b0, k_reg} + 1'b1;
    assign k_wrap = (10'(k_inc) >= 10'(key_len));

    // S[y] was written in the same cycle that S[t] was read
    assign ks_byte = (t_reg == y_reg) ? sx_reg : sbox_rdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ix_reg        <= '0;
            iy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            ix_reg        <= ix_next;
            iy_reg        <= iy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        t_reg        <= t_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        ix_next        = ix_reg;
        iy_next        = iy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        t_next         = t_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        data_next      = data_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        add_a          = '0;
        add_b          = '0;
        add_c          = '0;
        sbox_req       = '0;
        key_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(operation))
                        OP_KEY:
                        begin
                            key_req.wr_en   = 1'b1;
                            key_req.wr_addr = key_index;
                            key_req.wr_data = value;
                        end
                        OP_RESTART:
                        begin
                            sbox_req.clear = 1'b1;
                            i_next         = '0;
                            j_next         = '0;
                            k_next         = '0;
                            ix_next        = '0;
                            iy_next        = '0;
                            state_next     = ST_KS_RD_I;
                        end
                        OP_CRYPT:
                        begin
                            data_next  = value;
                            state_next = ST_CR_RD_X;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // key schedule: read S[i], read S[j], write S[i], write S[j] per step
            ST_KS_RD_I:
            begin
                sbox_req.rd_en   = 1'b1;
                sbox_req.rd_addr = i_reg;
                key_req.rd_en    = 1'b1;
                key_req.rd_addr  = 8'(k_reg);
                state_next       = ST_KS_RD_J;
            end
            ST_KS_RD_J:
            begin
                add_a            = j_reg;
                add_b            = sbox_rdata;
                add_c            = key_rdata;
                j_next           = add_sum;
                sx_next          = sbox_rdata;
                sbox_req.rd_en   = 1'b1;
                sbox_req.rd_addr = add_sum;
                state_next       = ST_KS_WR_I;
            end
            ST_KS_WR_I:
            begin
                sbox_req.wr_en   = 1'b1;
                sbox_req.wr_addr = i_reg;
                sbox_req.wr_data = sbox_rdata;
                state_next       = ST_KS_WR_J;
            end
            ST_KS_WR_J:
            begin
                sbox_req.wr_en   = 1'b1;
                sbox_req.wr_addr = j_reg;
                sbox_req.wr_data = sx_reg;
                i_next           = i_reg + 1'b1;
                k_next           = k_wrap ? '0 : k_inc[KIDX_W-1:0];
                state_next       = (i_reg == 8'hFF) ? ST_IDLE : ST_KS_RD_I;
            end

            // keystream byte
            ST_CR_RD_X:
            begin
                add_a            = ix_reg;
                add_b            = 8'd1;
                x_next           = add_sum;
                sbox_req.rd_en   = 1'b1;
                sbox_req.rd_addr = add_sum;
                state_next       = ST_CR_RD_Y;
            end
            ST_CR_RD_Y:
            begin
                add_a            = iy_reg;
                add_b            = sbox_rdata;
                y_next           = add_sum;
                sx_next          = sbox_rdata;
                sbox_req.rd_en   = 1'b1;
                sbox_req.rd_addr = add_sum;
                state_next       = ST_CR_WR_X;
            end
            ST_CR_WR_X:
            begin
                sy_next          = sbox_rdata;
                sbox_req.wr_en   = 1'b1;
                sbox_req.wr_addr = x_reg;
                sbox_req.wr_data = sbox_rdata;
                state_next       = ST_CR_WR_Y;
            end
            ST_CR_WR_Y:
            begin
                add_a            = sx_reg;
                add_b            = sy_reg;
                t_next           = add_sum;
                sbox_req.wr_en   = 1'b1;
                sbox_req.wr_addr = y_reg;
                sbox_req.wr_data = sx_reg;
                sbox_req.rd_en   = 1'b1;
                sbox_req.rd_addr = add_sum;
                ix_next          = x_reg;
                iy_next          = y_reg;
                state_next       = ST_CR_DONE;
            end
            ST_CR_DONE:
            begin
                // hold here while the previous result is still pending
                if (!out_valid_reg || out_ready)
                begin
                    out_byte_next  = data_reg ^ ks_byte;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte cipher: key byte writes, key schedule restart, data byte crypt.
// ----------------------------------------------------------------------------
//  channel   signals                         role
//  request   in_valid/in_ready               operation, key_index, value
//  result    out_valid/out_ready             out_byte (crypt requests only)
//  config    cfg_we                          cfg_data -> key length register
//
//  Key write: in_ready stays high.
//  Restart: four accesses of the permutation memory per key schedule step,
//  over all 256 steps; identity is restored at once by clearing the
//  per-entry valid bits, so there is no clearing pass.
//  Crypt: busy from accept through the memory access states RD_X, RD_Y, WR_X
//  and WR_Y, then DONE loads the output, waiting while a result is pending.
//  Reset: permutation identity, key store zero, indices zero, key length 16.
// ----------------------------------------------------------------------------
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_DEPTH = DEFAULT_KEY_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [BYTE_W-1:0]    key_index,
    input  logic [BYTE_W-1:0]    value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    input  logic                 cfg_we,
    input  logic [KEY_LEN_W-1:0] cfg_data
);

    localparam logic [KEY_LEN_W-1:0] DEPTH_LEN = KEY_LEN_W'(KEY_DEPTH);

    logic [KEY_LEN_W-1:0] klen_cfg_reg, klen_cfg_next;
    logic [KEY_LEN_W-1:0] key_len_eff;
    sbox_req_t            sbox_req;
    key_req_t             key_req;
    logic [BYTE_W-1:0]    sbox_rdata;
    logic [BYTE_W-1:0]    key_rdata;

    assign klen_cfg_next = cfg_we ? cfg_data : klen_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klen_cfg_reg <= KEY_LEN_RESET;
        end
        else
        begin
            klen_cfg_reg <= klen_cfg_next;
        end
    end

    // zero acts as one, anything past the store depth saturates
    always_comb
    begin
        if (klen_cfg_reg == '0)
        begin
            key_len_eff = KEY_LEN_W'(1);
        end
        else if (klen_cfg_reg > DEPTH_LEN)
        begin
            key_len_eff = DEPTH_LEN;
        end
        else
        begin
            key_len_eff = klen_cfg_reg;
        end
    end

    rc4_ctrl #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key_index  (key_index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .key_len    (key_len_eff),
        .sbox_req   (sbox_req),
        .sbox_rdata (sbox_rdata),
        .key_req    (key_req),
        .key_rdata  (key_rdata)
    );

    rc4_sbox_ram u_sbox (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sbox_req),
        .rdata (sbox_rdata)
    );

    rc4_key_ram #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_key (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (key_req),
        .rdata (key_rdata)
    );

endmodule

// File: sv/rc4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks on the RC4 cipher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_checker
    import rc4_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        operation,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte
);

    logic acc_crypt;
    logic acc_short;

    assign acc_crypt = in_valid && in_ready && (operation == OP_CRYPT);
    assign acc_short = in_valid && in_ready &&
                       ((operation == OP_KEY) || (operation == OP_NONE));

    // pending result holds until taken
    `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte))
    // a crypt request occupies the block
    `ASSERT_PROP(a_crypt_busy, clk, rst_n, acc_crypt |=> !in_ready)
    // key writes and unused codes never stall the request side
    `ASSERT_PROP(a_short_ready, clk, rst_n, acc_short |=> in_ready)
    // a new result only appears after a busy cycle
    `ASSERT_PROP(a_result_busy, clk, rst_n, $rose(out_valid) |-> $past(!in_ready))
    // no result right after a crypt request is taken
    `ASSERT_NEVER(a_no_early_out, clk, rst_n, $past(acc_crypt) && $rose(out_valid))

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (.*);
